>>> rtl/core/assert_macros.svh
// assertion macros shared by the pooling window rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PWIN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("pwin check failed");
`define PWIN_NEVER(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error("pwin check failed");
`else
`define PWIN_ASSERT(lbl, clk, rst, prop)
`define PWIN_NEVER(lbl, clk, rst, prop)
`endif
`endif

>>> rtl/core/pwin_pkg.sv
// shared types and constants of the 2x2 pooling window unit
`timescale 1ns / 1ps
package pwin_pkg;

  localparam int MAX_ROW_PIXELS = 1024;
  localparam int LANES          = 4;
  localparam int LANE_W         = 8;
  localparam int PIX_W          = LANE_W * LANES;
  localparam int COL_W          = $clog2(MAX_ROW_PIXELS);

  localparam int PW_W  = 11;
  localparam int OW_W  = 11;
  localparam int OH_W  = 13;
  localparam int ROW_W = 13;

  // widths for effective row width and output column and row compares
  localparam int EW_W  = (COL_W + 1 > PW_W) ? COL_W + 1 : PW_W;
  localparam int CMP_W = ((COL_W > OW_W) ? COL_W : OW_W) + 1;
  localparam int OHC_W = ((ROW_W > OH_W) ? ROW_W : OH_W) + 1;

  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [LANE_W-1:0] PAD_MAX = 8'h80;
  localparam logic [LANE_W-1:0] PAD_AVG = 8'h00;

  localparam int NUM_REGS  = 5;
  localparam int ADDR_W    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int DATA_W    = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POOL_MODE    = 0,
    REG_STRIDE_TWO   = 1,
    REG_PADDED_WIDTH = 2,
    REG_OUT_WIDTH    = 3,
    REG_OUT_HEIGHT   = 4
  } reg_idx_t;

  typedef struct packed {
    logic            pool_mode;
    logic            stride_two;
    logic [PW_W-1:0] padded_width;
    logic [OW_W-1:0] out_width;
    logic [OH_W-1:0] out_height;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper_left;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] cur;
    logic             last;
  } win_t;

endpackage

>>> rtl/core/pwin_ifs.sv
// stream interfaces for input pixels and pooled results
`timescale 1ns / 1ps
interface pwin_px_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] chan_a;
  logic signed [7:0] chan_b;
  logic signed [7:0] chan_c;
  logic signed [7:0] chan_d;
  logic              is_pad;
  logic              start_of_image;

  modport source (output valid, chan_a, chan_b, chan_c, chan_d, is_pad, start_of_image,
                  input ready);
  modport sink   (input valid, chan_a, chan_b, chan_c, chan_d, is_pad, start_of_image,
                  output ready);
endinterface

interface pwin_res_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] res_a;
  logic signed [7:0] res_b;
  logic signed [7:0] res_c;
  logic signed [7:0] res_d;
  logic              last_of_image;

  modport source (output valid, res_a, res_b, res_c, res_d, last_of_image, input ready);
  modport sink   (input valid, res_a, res_b, res_c, res_d, last_of_image, output ready);
endinterface

>>> rtl/core/pooling_2x2_int8_window_unit.sv
// 2x2 max / average pooling over a four-lane int8 pixel stream
// one pixel per cycle when not stalled, set by the single line buffer access per pixel
// a pooled result goes from stage a through the queue into the output register
// the front stage, a two-entry queue and the output register stall independently
// reset (synchronous, active high) clears counters, held pixels, queue and output valid
// the line buffer is not cleared; configuration resets to max mode, stride one, 2x1x1
`timescale 1ns / 1ps
module pooling_2x2_int8_window_unit (
  input  logic                         clk,
  input  logic                         rst,
  pwin_px_if.sink                      pix,
  pwin_res_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwin_pkg::ADDR_W-1:0]  paddr,
  input  logic [pwin_pkg::DATA_W-1:0]  pwdata,
  output logic [pwin_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  pwin_pkg::cfg_t cfg;
  pwin_pkg::win_t fe_win;
  pwin_pkg::win_t q_win;
  logic           fe_valid;
  logic           fe_ready;
  logic           q_valid;
  logic           q_ready;

  pwin_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwin_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix       (pix),
    .win       (fe_win),
    .win_valid (fe_valid),
    .win_ready (fe_ready)
  );

  pwin_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (fe_win),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .pop_data   (q_win),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  pwin_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pool_mode (cfg.pool_mode),
    .q_data    (q_win),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .res       (res)
  );

endmodule

>>> rtl/core/pwin_cfg.sv
// apb configuration registers of the pooling window unit
`timescale 1ns / 1ps
module pwin_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwin_pkg::ADDR_W-1:0]  paddr,
  input  logic [pwin_pkg::DATA_W-1:0]  pwdata,
  output logic [pwin_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output pwin_pkg::cfg_t               cfg
);

  pwin_pkg::reg_idx_t idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = pwin_pkg::reg_idx_t'(paddr[pwin_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_mode    <= 1'b0;
      cfg.stride_two   <= 1'b0;
      cfg.padded_width <= pwin_pkg::PW_W'(2);
      cfg.out_width    <= pwin_pkg::OW_W'(1);
      cfg.out_height   <= pwin_pkg::OH_W'(1);
    end else if (wr_en) begin
      case (idx)
        pwin_pkg::REG_POOL_MODE:    cfg.pool_mode    <= pwdata[0];
        pwin_pkg::REG_STRIDE_TWO:   cfg.stride_two   <= pwdata[0];
        pwin_pkg::REG_PADDED_WIDTH: cfg.padded_width <= pwdata[pwin_pkg::PW_W-1:0];
        pwin_pkg::REG_OUT_WIDTH:    cfg.out_width    <= pwdata[pwin_pkg::OW_W-1:0];
        pwin_pkg::REG_OUT_HEIGHT:   cfg.out_height   <= pwdata[pwin_pkg::OH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pwin_pkg::REG_POOL_MODE:    prdata = pwin_pkg::DATA_W'(cfg.pool_mode);
      pwin_pkg::REG_STRIDE_TWO:   prdata = pwin_pkg::DATA_W'(cfg.stride_two);
      pwin_pkg::REG_PADDED_WIDTH: prdata = pwin_pkg::DATA_W'(cfg.padded_width);
      pwin_pkg::REG_OUT_WIDTH:    prdata = pwin_pkg::DATA_W'(cfg.out_width);
      pwin_pkg::REG_OUT_HEIGHT:   prdata = pwin_pkg::DATA_W'(cfg.out_height);
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/pwin_front.sv
// front end: raster counters, window placement and line buffer
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pwin_front (
  input  logic           clk,
  input  logic           rst,
  input  pwin_pkg::cfg_t cfg,
  pwin_px_if.sink        pix,
  output pwin_pkg::win_t win,
  output logic           win_valid,
  input  logic           win_ready
);

  localparam int COL_W = pwin_pkg::COL_W;
  localparam int ROW_W = pwin_pkg::ROW_W;
  localparam int EW_W  = pwin_pkg::EW_W;
  localparam int CMP_W = pwin_pkg::CMP_W;
  localparam int OHC_W = pwin_pkg::OHC_W;
  localparam int PIX_W = pwin_pkg::PIX_W;

  logic [PIX_W-1:0] line_mem [pwin_pkg::MAX_ROW_PIXELS];

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] prev_above;
  logic [PIX_W-1:0] above_q;

  // stage a holds the request while its line buffer read lands
  logic             a_valid;
  logic             a_emit;
  logic             a_last;
  logic [PIX_W-1:0] a_px;
  logic [PIX_W-1:0] a_left;
  logic             a_move;

  logic             accept;
  logic [PIX_W-1:0] px_in;
  logic [7:0]       pad_byte;
  logic [EW_W-1:0]  pw_ext;
  logic [EW_W-1:0]  width;
  logic [COL_W-1:0] col0;
  logic [COL_W-1:0] col_sof;
  logic [ROW_W-1:0] row0;
  logic [EW_W-1:0]  col_inc;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [ROW_W-1:0] oh;
  logic [COL_W-1:0] ow;
  logic [CMP_W-1:0] ow_ext;
  logic [OHC_W-1:0] oh_ext;
  logic             place_ok;
  logic             emit;
  logic             last;

  assign a_move    = a_valid && (!a_emit || win_ready);
  assign pix.ready = !a_valid || a_move;
  assign accept    = pix.valid && pix.ready;
  assign win_valid = a_valid && a_emit;

  always_comb begin
    pad_byte = cfg.pool_mode ? pwin_pkg::PAD_AVG : pwin_pkg::PAD_MAX;
    if (pix.is_pad) begin
      px_in = {pwin_pkg::LANES{pad_byte}};
    end else begin
      px_in = {pix.chan_d, pix.chan_c, pix.chan_b, pix.chan_a};
    end

    // row width clamped to 1..MAX_ROW_PIXELS
    pw_ext = EW_W'(cfg.padded_width);
    if (pw_ext > EW_W'(pwin_pkg::MAX_ROW_PIXELS)) begin
      width = EW_W'(pwin_pkg::MAX_ROW_PIXELS);
    end else if (pw_ext == '0) begin
      width = EW_W'(1);
    end else begin
      width = pw_ext;
    end

    col_sof = pix.start_of_image ? '0 : col_count;
    row0    = pix.start_of_image ? '0 : row_count;
    col0    = (EW_W'(col_sof) >= width) ? '0 : col_sof;

    col_inc = EW_W'(col0) + EW_W'(1);
    if (col_inc >= width) begin
      col_next = '0;
      row_next = row0 + ROW_W'(1);
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row0;
    end

    if (cfg.stride_two) begin
      place_ok = row0[0] && col0[0];
      oh       = (row0 - ROW_W'(1)) >> 1;
      ow       = (col0 - COL_W'(1)) >> 1;
    end else begin
      place_ok = 1'b1;
      oh       = row0 - ROW_W'(1);
      ow       = col0 - COL_W'(1);
    end
    ow_ext = CMP_W'(ow);
    oh_ext = OHC_W'(oh);
    emit   = (row0 != '0) && (col0 != '0) && place_ok &&
             (oh_ext < OHC_W'(cfg.out_height)) && (ow_ext < CMP_W'(cfg.out_width));
    last   = (oh_ext + OHC_W'(1) == OHC_W'(cfg.out_height)) &&
             (ow_ext + CMP_W'(1) == CMP_W'(cfg.out_width));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      left_px    <= '0;
      prev_above <= '0;
      a_valid    <= 1'b0;
      a_emit     <= 1'b0;
    end else begin
      if (a_move) begin
        prev_above <= above_q;
      end
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
        left_px   <= px_in;
        a_valid   <= 1'b1;
        a_emit    <= emit;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px   <= px_in;
      a_left <= left_px;
      a_last <= last;
    end
  end

  // line buffer: read old entry and write the new pixel at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      above_q        <= line_mem[col0];
      line_mem[col0] <= px_in;
    end
  end

  assign win = '{upper_left: prev_above, upper: above_q, left: a_left, cur: a_px,
                 last: a_last};

  `PWIN_ASSERT(a_hold_chk, clk, rst, a_valid && !a_move |=> a_valid && $stable(a_px))
  `PWIN_NEVER(no_take_while_held, clk, rst, accept && a_valid && !a_move)

endmodule

>>> rtl/core/pwin_queue.sv
// short queue of complete windows between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pwin_queue (
  input  logic           clk,
  input  logic           rst,
  input  pwin_pkg::win_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output pwin_pkg::win_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);

  localparam int QP_W = pwin_pkg::QP_W;
  localparam int QC_W = pwin_pkg::QC_W;

  pwin_pkg::win_t  slots [pwin_pkg::Q_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = count != QC_W'(pwin_pkg::Q_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(pwin_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(pwin_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      if (push && !pop) begin
        count <= count + QC_W'(1);
      end else if (pop && !push) begin
        count <= count - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `PWIN_NEVER(q_overflow, clk, rst, count > QC_W'(pwin_pkg::Q_DEPTH))
  `PWIN_ASSERT(q_fill_step, clk, rst, push && !pop |=> count == $past(count) + 1)

endmodule

>>> rtl/core/pwin_back.sv
// back end: per-lane max or rounded average and the result register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pwin_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pool_mode,
  input  pwin_pkg::win_t q_data,
  input  logic           q_valid,
  output logic           q_ready,
  pwin_res_if.source     res
);

  function automatic logic [7:0] pool_lane(input logic mode, input logic signed [7:0] p0,
                                           input logic signed [7:0] p1,
                                           input logic signed [7:0] p2,
                                           input logic signed [7:0] p3);
    logic signed [9:0]  s;
    logic [10:0]        t;
    logic [10:0]        mag;
    logic signed [7:0]  m;
    logic [7:0]         r;
    s   = {{2{p0[7]}}, p0} + {{2{p1[7]}}, p1} + {{2{p2[7]}}, p2} + {{2{p3[7]}}, p3};
    t   = {s[9], s} + 11'd2;
    mag = 11'd2 - {s[9], s};
    m   = p0;
    if (p1 > m) m = p1;
    if (p2 > m) m = p2;
    if (p3 > m) m = p3;
    if (!mode) begin
      r = m;
    end else if (s > 10'sd0) begin
      r = t[9:2];
    end else begin
      // round half away from zero on the magnitude, then negate
      r = 8'(~mag[10:2] + 9'd1);
    end
    return r;
  endfunction

  logic [7:0] lane_res [pwin_pkg::LANES];
  logic       res_valid;
  logic       take;

  assign q_ready   = !res_valid || res.ready;
  assign take      = q_valid && q_ready;
  assign res.valid = res_valid;

  always_comb begin
    for (int i = 0; i < pwin_pkg::LANES; i++) begin
      lane_res[i] = pool_lane(pool_mode, q_data.upper_left[8*i +: 8], q_data.upper[8*i +: 8],
                              q_data.left[8*i +: 8], q_data.cur[8*i +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_ready) begin
      res_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.res_a         <= lane_res[0];
      res.res_b         <= lane_res[1];
      res.res_c         <= lane_res[2];
      res.res_d         <= lane_res[3];
      res.last_of_image <= q_data.last;
    end
  end

  `PWIN_ASSERT(take_loads_out, clk, rst, take |=> res_valid)

endmodule

>>> bench/pooling_2x2_int8_window_unit_tb.sv
// self-checking testbench for the 2x2 max / average pooling window unit
`timescale 1ns / 1ps
module pooling_2x2_int8_window_unit_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WIN_SETTLE  = 8;
  localparam int RAND_PIXELS = 680;

  typedef struct packed {
    logic [pwin_pkg::LANES-1:0][pwin_pkg::LANE_W-1:0] lane;
    logic                                             pad;
    logic                                             sof;
  } pixel_t;

  typedef struct packed {
    logic [pwin_pkg::LANES-1:0][pwin_pkg::LANE_W-1:0] lane;
    logic                                             last;
  } pooled_t;

  typedef struct {
    bit                  is_cfg;
    pwin_pkg::reg_idx_t  reg_sel;
    int unsigned         reg_val;
    pixel_t              px;
    bit                  typed;
    pooled_t             want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [pwin_pkg::ADDR_W-1:0]   paddr;
  logic [pwin_pkg::DATA_W-1:0]   pwdata;
  logic [pwin_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  pwin_px_if  pix ();
  pwin_res_if res ();

  pooling_2x2_int8_window_unit uut (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // window predictor state
  pwin_pkg::cfg_t              shadow_cfg;
  logic [pwin_pkg::PIX_W-1:0]  line_mem [pwin_pkg::MAX_ROW_PIXELS];
  logic [pwin_pkg::PIX_W-1:0]  upper_left_px;
  logic [pwin_pkg::PIX_W-1:0]  left_px;
  int                          col_pos;
  int                          row_pos;

  pooled_t  pooled_q [$];
  dir_row_t dir_rows [$];
  string    lane_names [pwin_pkg::LANES] = '{"res_a", "res_b", "res_c", "res_d"};
  int       mismatch_count = 0;
  int       px_accepted = 0;
  int       cycle_count = 0;
  int       rx_hold;
  bit       no_idle = 1'b0;

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic int eff_width();
    int w;
    w = int'(shadow_cfg.padded_width);
    if (w > pwin_pkg::MAX_ROW_PIXELS) w = pwin_pkg::MAX_ROW_PIXELS;
    if (w < 1) w = 1;
    return w;
  endfunction

  function automatic bit pool_window(input pixel_t p, output pooled_t r);
    int                          w, oh, ow, acc, v;
    int                          lv [4];
    logic [pwin_pkg::PIX_W-1:0]  cur, above;
    bit                          hit;
    w = eff_width();
    if (p.sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (p.pad) begin
      cur = shadow_cfg.pool_mode ? {pwin_pkg::LANES{pwin_pkg::PAD_AVG}}
                                 : {pwin_pkg::LANES{pwin_pkg::PAD_MAX}};
    end else begin
      cur = p.lane;
    end
    above = line_mem[col_pos];
    hit = 1'b0;
    r = '0;
    if (row_pos >= 1 && col_pos >= 1) begin
      if (shadow_cfg.stride_two) begin
        hit = row_pos[0] && col_pos[0];
        oh = (row_pos - 1) / 2;
        ow = (col_pos - 1) / 2;
      end else begin
        hit = 1'b1;
        oh = row_pos - 1;
        ow = col_pos - 1;
      end
      hit = hit && oh < int'(shadow_cfg.out_height) && ow < int'(shadow_cfg.out_width);
      if (hit) begin
        for (int i = 0; i < pwin_pkg::LANES; i++) begin
          lv[0] = $signed(upper_left_px[i*pwin_pkg::LANE_W +: pwin_pkg::LANE_W]);
          lv[1] = $signed(above[i*pwin_pkg::LANE_W +: pwin_pkg::LANE_W]);
          lv[2] = $signed(left_px[i*pwin_pkg::LANE_W +: pwin_pkg::LANE_W]);
          lv[3] = $signed(cur[i*pwin_pkg::LANE_W +: pwin_pkg::LANE_W]);
          if (shadow_cfg.pool_mode) begin
            acc = lv[0] + lv[1] + lv[2] + lv[3];
            // half away from zero, then truncate toward zero
            v = (acc > 0) ? (acc + 2) / 4 : (acc - 2) / 4;
          end else begin
            v = lv[0];
            for (int k = 1; k < 4; k++) if (lv[k] > v) v = lv[k];
          end
          r.lane[i] = v[pwin_pkg::LANE_W-1:0];
        end
        r.last = (oh + 1 == int'(shadow_cfg.out_height)) &&
                 (ow + 1 == int'(shadow_cfg.out_width));
      end
    end
    upper_left_px = above;
    line_mem[col_pos] = cur;
    left_px = cur;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & ((1 << pwin_pkg::ROW_W) - 1);
    end
    return hit;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     sel;
    for (int i = 0; i < pwin_pkg::LANES; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       p.lane[i] = 8'h80;
        1:       p.lane[i] = 8'h7f;
        2, 3, 4: p.lane[i] = pwin_pkg::LANE_W'($urandom_range(0, 6) - 3);
        default: p.lane[i] = pwin_pkg::LANE_W'($urandom_range(0, 255));
      endcase
    end
    p.pad = ($urandom_range(0, 5) == 0);
    p.sof = 1'b0;
    return p;
  endfunction

  function automatic void dir_px(int a, int b, int c, int d, bit pad, bit sof,
                                 bit typed = 1'b0, int e = 0);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.reg_sel = pwin_pkg::REG_POOL_MODE;
    row.reg_val = 0;
    row.px.lane = {d[7:0], c[7:0], b[7:0], a[7:0]};
    row.px.pad = pad;
    row.px.sof = sof;
    row.typed = typed;
    // typed rows all close a window at the last output position
    row.want.lane = {pwin_pkg::LANES{e[7:0]}};
    row.want.last = 1'b1;
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_cfg(pwin_pkg::reg_idx_t r, int unsigned v);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.reg_sel = r;
    row.reg_val = v;
    row.px = '0;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  task automatic send_px(input pixel_t p, input bit typed = 1'b0, input pooled_t want = '0);
    int      gap;
    pooled_t got;
    bit      hit;
    gap = draw_wait();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid          <= 1'b1;
    pix.chan_a         <= p.lane[0];
    pix.chan_b         <= p.lane[1];
    pix.chan_c         <= p.lane[2];
    pix.chan_d         <= p.lane[3];
    pix.is_pad         <= p.pad;
    pix.start_of_image <= p.sof;
    do @(posedge clk); while (!pix.ready);
    px_accepted++;
    hit = pool_window(p, got);
    if (typed) pooled_q.push_back(want);
    else if (hit) pooled_q.push_back(got);
  endtask

  // hold off the pixel stream until every pooled result is back
  task automatic drain(input int extra);
    pix.valid <= 1'b0;
    do @(posedge clk); while (pooled_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic reg_write(input pwin_pkg::reg_idx_t idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pwin_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pwin_pkg::REG_POOL_MODE:    shadow_cfg.pool_mode    = value[0];
      pwin_pkg::REG_STRIDE_TWO:   shadow_cfg.stride_two   = value[0];
      pwin_pkg::REG_PADDED_WIDTH: shadow_cfg.padded_width = value[pwin_pkg::PW_W-1:0];
      pwin_pkg::REG_OUT_WIDTH:    shadow_cfg.out_width    = value[pwin_pkg::OW_W-1:0];
      pwin_pkg::REG_OUT_HEIGHT:   shadow_cfg.out_height   = value[pwin_pkg::OH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input bit mode, input bit stride, input int pw, input int ow,
                            input int oh);
    drain(WIN_SETTLE);
    reg_write(pwin_pkg::REG_POOL_MODE, mode);
    reg_write(pwin_pkg::REG_STRIDE_TWO, stride);
    reg_write(pwin_pkg::REG_PADDED_WIDTH, pw);
    reg_write(pwin_pkg::REG_OUT_WIDTH, ow);
    reg_write(pwin_pkg::REG_OUT_HEIGHT, oh);
  endtask

  task automatic send_run(input int n, input bit sof_first, input bit noise);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p = rand_pixel();
      p.sof = (i == 0 && sof_first) || (noise && $urandom_range(0, 99) == 0);
      send_px(p);
    end
  endtask

  // one image of full rows, now and then cut short
  task automatic send_image(input int rows);
    int n;
    n = eff_width() * rows;
    no_idle = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
    send_run(n, 1'b1, 1'b1);
  endtask

  function automatic int rows_for();
    int oh;
    oh = int'(shadow_cfg.out_height);
    if (oh > 3) oh = 3;
    return (shadow_cfg.stride_two ? 2 * oh + 1 : oh + 1) + int'($urandom_range(0, 1));
  endfunction

  // pooled result sink: random stalls and in-order compare
  always @(posedge clk) begin
    pooled_t got;
    pooled_t want;
    if (rst) begin
      res.ready <= 1'b0;
      rx_hold = draw_wait();
    end else if (res.valid && res.ready) begin
      got.lane = {res.res_d, res.res_c, res.res_b, res.res_a};
      got.last = res.last_of_image;
      if (pooled_q.size() == 0) begin
        $error("pooled result with no request waiting");
        mismatch_count++;
      end else begin
        want = pooled_q.pop_front();
        for (int i = 0; i < pwin_pkg::LANES; i++) begin
          if (got.lane[i] !== want.lane[i]) begin
            $error("%s expected %0d actual %0d", lane_names[i], $signed(want.lane[i]),
                   $signed(got.lane[i]));
            mismatch_count++;
          end
        end
        if (got.last !== want.last) begin
          $error("last_of_image expected %0b actual %0b", want.last, got.last);
          mismatch_count++;
        end
      end
      rx_hold = draw_wait();
      res.ready <= (rx_hold == 0);
    end else if (!res.ready) begin
      if (rx_hold > 0) rx_hold--;
      res.ready <= (rx_hold == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL pooling_2x2_int8_window_unit");
    $finish;
  end

  initial begin
    int start_cnt;
    int pw;
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.chan_a = '0;
    pix.chan_b = '0;
    pix.chan_c = '0;
    pix.chan_d = '0;
    pix.is_pad = 1'b0;
    pix.start_of_image = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_cfg = '{pool_mode: 1'b0, stride_two: 1'b0, padded_width: 2, out_width: 1,
                   out_height: 1};
    foreach (line_mem[i]) line_mem[i] = '0;
    upper_left_px = '0;
    left_px = '0;
    col_pos = 0;
    row_pos = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // max mode at reset settings, then average mode: 2x2 images opened by start of image
    dir_px(127, -128, 0, 1, 1'b0, 1'b1);
    dir_px(-128, 127, -1, 0, 1'b0, 1'b0);
    dir_px(127, 127, 127, 127, 1'b1, 1'b0);
    dir_px(-128, -128, 127, 127, 1'b0, 1'b0, 1'b1, 127);
    dir_px(3, -3, 0, 0, 1'b0, 1'b0);
    dir_px(-1, 1, 2, -2, 1'b0, 1'b0);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b1);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b0);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b0);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b0, 1'b1, -128);
    dir_cfg(pwin_pkg::REG_POOL_MODE, 1);
    dir_px(-128, -128, -128, -128, 1'b1, 1'b1);
    dir_px(-128, -128, -128, -128, 1'b1, 1'b0);
    dir_px(-128, -128, -128, -128, 1'b1, 1'b0);
    dir_px(-128, -128, -128, -128, 1'b1, 1'b0, 1'b1, 0);
    dir_px(127, 127, 127, 127, 1'b0, 1'b1);
    dir_px(127, 127, 127, 127, 1'b0, 1'b0);
    dir_px(127, 127, 127, 127, 1'b0, 1'b0);
    dir_px(127, 127, 127, 127, 1'b0, 1'b0, 1'b1, 127);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b1);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b0);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b0);
    dir_px(-128, -128, -128, -128, 1'b0, 1'b0, 1'b1, -128);
    // rounding at sums of +-2 and +-1
    dir_px(1, -1, 0, 0, 1'b0, 1'b1);
    dir_px(1, -1, 0, 0, 1'b0, 1'b0);
    dir_px(0, 0, 1, -1, 1'b0, 1'b0);
    dir_px(0, 0, 0, 0, 1'b0, 1'b0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain(WIN_SETTLE);
        reg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      end else begin
        send_px(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // degenerate widths and output sizes
    set_config(1'b0, 1'b0, 0, 1, 1);
    send_image(6);
    set_config(1'b1, 1'b1, 1, 2047, 8191);
    send_image(6);
    set_config(1'b0, 1'b0, 6, 0, 3);
    send_image(4);
    set_config(1'b1, 1'b0, 6, 3, 0);
    send_image(3);
    set_config(1'($urandom_range(0, 1)), 1'b0, 5, 2047, 8191);
    send_image(5);

    start_cnt = px_accepted;
    while (px_accepted - start_cnt < RAND_PIXELS) begin
      pw = $urandom_range(2, 9);
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pw,
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, pw),
                 ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) drain(0);
        send_image(rows_for());
      end
    end

    drain(WIN_SETTLE);
    if (mismatch_count == 0) begin
      $display("PASS pooling_2x2_int8_window_unit");
    end else begin
      $display("FAIL pooling_2x2_int8_window_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pwin_pkg.sv
rtl/core/pwin_ifs.sv
rtl/core/pwin_cfg.sv
rtl/core/pwin_front.sv
rtl/core/pwin_queue.sv
rtl/core/pwin_back.sv
rtl/core/pooling_2x2_int8_window_unit.sv
bench/pooling_2x2_int8_window_unit_tb.sv
